>>> hw/rtl/mct_pkg.sv
// shared types, constants and helpers of the macd crossover trader
package mct_pkg;

   localparam int MAX_WINDOW = 32;
   localparam int HIST_DEPTH = MAX_WINDOW + 1;
   localparam int ADDR_W     = $clog2(HIST_DEPTH);
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
   localparam longint WONE   = 64'd1 << 24;

   // q.24 decay factor per window size, (n-3)/(n-1); size 2 carries magnitude 1.0
   localparam logic [24:0] ALPHA_TABLE [0:32] = '{
      25'd0, 25'd0, 25'(WONE), 25'd0,
      25'((1 * WONE) / 3),   25'((2 * WONE) / 4),   25'((3 * WONE) / 5),
      25'((4 * WONE) / 6),   25'((5 * WONE) / 7),   25'((6 * WONE) / 8),
      25'((7 * WONE) / 9),   25'((8 * WONE) / 10),  25'((9 * WONE) / 11),
      25'((10 * WONE) / 12), 25'((11 * WONE) / 13), 25'((12 * WONE) / 14),
      25'((13 * WONE) / 15), 25'((14 * WONE) / 16), 25'((15 * WONE) / 17),
      25'((16 * WONE) / 18), 25'((17 * WONE) / 19), 25'((18 * WONE) / 20),
      25'((19 * WONE) / 21), 25'((20 * WONE) / 22), 25'((21 * WONE) / 23),
      25'((22 * WONE) / 24), 25'((23 * WONE) / 25), 25'((24 * WONE) / 26),
      25'((25 * WONE) / 27), 25'((26 * WONE) / 28), 25'((27 * WONE) / 29),
      25'((28 * WONE) / 30), 25'((29 * WONE) / 31)
   };

   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_BUY  = 2'd1;
   localparam logic [1:0] ACT_SELL = 2'd2;

   localparam logic [2:0] CSR_FAST_WINDOW   = 3'd0;
   localparam logic [2:0] CSR_SLOW_WINDOW   = 3'd1;
   localparam logic [2:0] CSR_SIGNAL_WINDOW = 3'd2;
   localparam logic [2:0] CSR_REBUY_RATIO   = 3'd3;
   localparam logic [2:0] CSR_SELL_FLOOR    = 3'd4;
   localparam logic [2:0] CSR_STOP_LOSS     = 3'd5;

   localparam logic [5:0]  RST_FAST_WINDOW   = 6'd12;
   localparam logic [5:0]  RST_SLOW_WINDOW   = 6'd26;
   localparam logic [5:0]  RST_SIGNAL_WINDOW = 6'd9;
   localparam logic [15:0] RST_REBUY_RATIO   = 16'd58982;
   localparam logic [15:0] RST_SELL_FLOOR    = 16'd62915;
   localparam logic [15:0] RST_STOP_LOSS     = 16'd55706;

   typedef struct packed {
      logic [31:0] price;
      logic        start_series;
   } req_type;

   typedef struct packed {
      logic signed [31:0] macd_value;
      logic signed [31:0] signal_value;
      logic [1:0]         action;
   } rsp_type;

   typedef struct packed {
      logic done;
      logic busy;
   } div_status_type;

   function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
      logic signed [31:0] r;
      if (v > 65'sd2147483647) r = 32'sh7fffffff;
      else if (v < -65'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

>>> hw/rtl/mct_ram.sv
// generic single write, single read ram with registered read data
module mct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 33
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/mct_divider.sv
// signed 64 by unsigned 32 divider, two quotient bits per cycle, truncating
module mct_divider import mct_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] dividend,
   input  logic [31:0]        divisor,
   output logic signed [63:0] quotient,
   output div_status_type     status
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        neg_ff, neg_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] den_ff, den_in;
   logic [31:0] rem_ff, rem_in;
   logic [63:0] dvd_ff, dvd_in;
   logic [32:0] r1, r2;
   logic [32:0] r1s, r2s;
   logic        ge1, ge2;

   always_comb begin
      r1  = {rem_ff, dvd_ff[63]};
      ge1 = r1 >= {1'b0, den_ff};
      r1s = ge1 ? r1 - {1'b0, den_ff} : r1;
      r2  = {r1s[31:0], dvd_ff[62]};
      ge2 = r2 >= {1'b0, den_ff};
      r2s = ge2 ? r2 - {1'b0, den_ff} : r2;

      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[63];
         dvd_in  = dividend[63] ? 64'(-dividend) : 64'(dividend);
         den_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[61:0], ge1, ge2};
         rem_in = r2s[31:0];
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign quotient    = neg_ff ? -$signed(dvd_ff) : $signed(dvd_ff);
   assign status.done = done_ff;
   assign status.busy = busy_ff;
endmodule

>>> hw/rtl/macd_crossover_trader.sv
// top level of the macd crossover trader: sequencer, mac datapath and trade logic
//
// one price beat in, one result beat out. each beat runs three truncated weighted
// averages (fast and slow over the price history, signal over the macd history).
// an average over n past samples steps through them on the history ram port
// (read, then multiply-accumulate, per sample), then runs the 64-bit divide
// (two quotient bits per cycle). n is the window clamped to the samples seen
// so far. a window of 0 or 1 skips the divide. the next price beat is taken as
// soon as the result sits in the output register, even while it waits for the
// consumer. the histories are circular rams of 33 entries that need no clearing:
// only entries written since the last start of series are read. csr writes are
// always ready and must only be issued while the block is idle.
module macd_crossover_trader import mct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_RD, S_MAC, S_DIV_GO, S_DIV_WAIT, S_END, S_MACD, S_DEC1, S_DEC2
   } state_type;

   typedef enum logic [1:0] {PASS_FAST, PASS_SLOW, PASS_SIGNAL} pass_type;

   state_type state_ff, state_in;
   pass_type  pass_ff, pass_in;

   // configuration
   logic [5:0]  fast_win_ff, slow_win_ff, sig_win_ff;
   logic [15:0] rebuy_ff, floor_ff, stop_ff;

   // per beat working registers
   logic [31:0]        price_ff, price_in;
   logic [ADDR_W-1:0]  head_ff, head_in, wptr_ff, wptr_in;
   logic [CNT_W-1:0]   k_ff, k_in, n_ff, n_in;
   logic [24:0]        mag_ff, mag_in;
   logic signed [63:0] num_ff, num_in;
   logic [31:0]        den_ff, den_in;
   logic signed [63:0] res_ff, res_in, fast_ff, fast_in, slow_ff, slow_in;
   logic signed [31:0] macd_ff, macd_in, signal_ff, signal_in;
   logic [47:0]        p_rebuy_ff, p_rebuy_in, p_floor_ff, p_floor_in, p_stop_ff, p_stop_in;
   logic               up_ff, up_in, down_ff, down_in;

   // series state
   logic [CNT_W-1:0]   count_ff, count_in;
   logic signed [31:0] prev_macd_ff, prev_macd_in, prev_sig_ff, prev_sig_in;
   logic               holding_ff, holding_in, traded_ff, traded_in;
   logic [31:0]        last_ff, last_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic                accept;
   logic                div_start;
   logic signed [63:0]  div_quot;
   div_status_type      div_stat;
   logic [31:0]         price_rd, macd_rd, hist_rd;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W:0]     rd_sum;
   logic                macd_we;
   logic signed [31:0]  macd_calc;
   logic [5:0]          win, win_c;
   logic [CNT_W-1:0]    n_calc;
   logic signed [32:0]  x0, xk;
   logic [49:0]         mag_prod;
   logic signed [58:0]  term;
   logic                neg_k;
   logic [47:0]         scaled;
   logic                last_nz, buy, sell;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // circular history read: k samples behind the newest entry
   assign rd_sum  = {1'b0, head_ff} + (ADDR_W + 1)'(HIST_DEPTH) - (ADDR_W + 1)'(k_ff);
   assign rd_addr = (rd_sum >= (ADDR_W + 1)'(HIST_DEPTH)) ?
                    ADDR_W'(rd_sum - (ADDR_W + 1)'(HIST_DEPTH)) : rd_sum[ADDR_W-1:0];

   assign macd_calc = sat32(65'(fast_ff) - 65'(slow_ff));
   assign macd_we   = state_ff == S_MACD;

   mct_ram #(.WIDTH(32), .DEPTH(HIST_DEPTH)) u_price_ram (
      .clock(clock), .wr_en(accept), .wr_addr(wptr_ff), .wr_data(req_data.price),
      .rd_addr(rd_addr), .rd_data(price_rd)
   );

   mct_ram #(.WIDTH(32), .DEPTH(HIST_DEPTH)) u_macd_ram (
      .clock(clock), .wr_en(macd_we), .wr_addr(head_ff), .wr_data(macd_calc),
      .rd_addr(rd_addr), .rd_data(macd_rd)
   );

   mct_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(num_ff),
      .divisor(den_ff), .quotient(div_quot), .status(div_stat)
   );

   always_comb begin
      // window of the running pass, clamped, then limited by samples seen
      case (pass_ff)
         PASS_FAST:   win = fast_win_ff;
         PASS_SLOW:   win = slow_win_ff;
         PASS_SIGNAL: win = sig_win_ff;
         default:     win = fast_win_ff;
      endcase
      win_c  = (win > 6'(MAX_WINDOW)) ? 6'(MAX_WINDOW) : win;
      n_calc = (count_ff < CNT_W'(win_c)) ? count_ff : CNT_W'(win_c);

      // prices are unsigned, macd values signed
      hist_rd = (pass_ff == PASS_SIGNAL) ? macd_rd : price_rd;
      x0 = (pass_ff == PASS_SIGNAL) ? {macd_ff[31], macd_ff} : {1'b0, price_ff};
      xk = (pass_ff == PASS_SIGNAL) ? {hist_rd[31], hist_rd} : {1'b0, hist_rd};

      mag_prod = mag_ff * ALPHA_TABLE[n_ff];
      term     = xk * $signed({1'b0, mag_ff});
      neg_k    = (n_ff == CNT_W'(2)) && k_ff[0];

      scaled  = {price_ff, 16'd0};
      last_nz = last_ff != 32'd0;
      buy  = !holding_ff && (up_ff || (traded_ff && last_nz && scaled <= p_rebuy_ff));
      sell = holding_ff && down_ff && last_nz &&
             (scaled >= p_floor_ff || scaled <= p_stop_ff);
   end

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      price_in     = price_ff;
      head_in      = head_ff;
      wptr_in      = wptr_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      mag_in       = mag_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      res_in       = res_ff;
      fast_in      = fast_ff;
      slow_in      = slow_ff;
      macd_in      = macd_ff;
      signal_in    = signal_ff;
      p_rebuy_in   = p_rebuy_ff;
      p_floor_in   = p_floor_ff;
      p_stop_in    = p_stop_ff;
      up_in        = up_ff;
      down_in      = down_ff;
      count_in     = count_ff;
      prev_macd_in = prev_macd_ff;
      prev_sig_in  = prev_sig_ff;
      holding_in   = holding_ff;
      traded_in    = traded_ff;
      last_in      = last_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      div_start    = 1'b0;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               price_in = req_data.price;
               head_in  = wptr_ff;
               wptr_in  = (wptr_ff == ADDR_W'(HIST_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
               pass_in  = PASS_FAST;
               if (req_data.start_series) begin
                  count_in     = '0;
                  prev_macd_in = '0;
                  prev_sig_in  = '0;
                  holding_in   = 1'b0;
                  traded_in    = 1'b0;
                  last_in      = '0;
               end
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            n_in   = n_calc;
            k_in   = CNT_W'(1);
            mag_in = 25'(WONE);
            num_in = 64'(x0) <<< 24;
            den_in = 32'(WONE);
            if (n_calc == '0) begin
               res_in   = 64'(x0);
               state_in = S_END;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            // ram address for sample k goes out, weight k formed alongside
            mag_in   = mag_prod[48:24];
            state_in = S_MAC;
         end
         S_MAC: begin
            if (n_ff == CNT_W'(1)) begin
               res_in   = 64'(xk);
               state_in = S_END;
            end else begin
               num_in = neg_k ? num_ff - 64'(term) : num_ff + 64'(term);
               den_in = neg_k ? den_ff - 32'(mag_ff) : den_ff + 32'(mag_ff);
               if (k_ff == n_ff) begin
                  state_in = S_DIV_GO;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_stat.done) begin
               res_in   = div_quot;
               state_in = S_END;
            end
         end
         S_END: begin
            case (pass_ff)
               PASS_FAST: begin
                  fast_in  = res_ff;
                  pass_in  = PASS_SLOW;
                  state_in = S_INIT;
               end
               PASS_SLOW: begin
                  slow_in  = res_ff;
                  state_in = S_MACD;
               end
               default: begin
                  signal_in = sat32(65'(res_ff));
                  state_in  = S_DEC1;
               end
            endcase
         end
         S_MACD: begin
            // macd lands in its history at the same slot as the price
            macd_in  = macd_calc;
            pass_in  = PASS_SIGNAL;
            state_in = S_INIT;
         end
         S_DEC1: begin
            up_in      = count_ff != '0 && prev_macd_ff < prev_sig_ff && macd_ff > signal_ff;
            down_in    = count_ff != '0 && prev_macd_ff > prev_sig_ff && macd_ff < signal_ff;
            p_rebuy_in = rebuy_ff * last_ff;
            p_floor_in = floor_ff * last_ff;
            p_stop_in  = stop_ff * last_ff;
            state_in   = S_DEC2;
         end
         S_DEC2: begin
            // commit only once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.macd_value   = macd_ff;
               rsp_in.signal_value = signal_ff;
               rsp_in.action       = ACT_NONE;
               if (buy || sell) begin
                  rsp_in.action = buy ? ACT_BUY : ACT_SELL;
                  holding_in    = !holding_ff;
                  traded_in     = 1'b1;
                  last_in       = price_ff;
               end
               if (count_ff < CNT_W'(MAX_WINDOW)) count_in = count_ff + 1'b1;
               prev_macd_in = macd_ff;
               prev_sig_in  = signal_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pass_ff      <= PASS_FAST;
         wptr_ff      <= '0;
         count_ff     <= '0;
         prev_macd_ff <= '0;
         prev_sig_ff  <= '0;
         holding_ff   <= 1'b0;
         traded_ff    <= 1'b0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         fast_win_ff  <= RST_FAST_WINDOW;
         slow_win_ff  <= RST_SLOW_WINDOW;
         sig_win_ff   <= RST_SIGNAL_WINDOW;
         rebuy_ff     <= RST_REBUY_RATIO;
         floor_ff     <= RST_SELL_FLOOR;
         stop_ff      <= RST_STOP_LOSS;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         wptr_ff      <= wptr_in;
         count_ff     <= count_in;
         prev_macd_ff <= prev_macd_in;
         prev_sig_ff  <= prev_sig_in;
         holding_ff   <= holding_in;
         traded_ff    <= traded_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FAST_WINDOW:   fast_win_ff <= csr_data[5:0];
               CSR_SLOW_WINDOW:   slow_win_ff <= csr_data[5:0];
               CSR_SIGNAL_WINDOW: sig_win_ff  <= csr_data[5:0];
               CSR_REBUY_RATIO:   rebuy_ff    <= csr_data;
               CSR_SELL_FLOOR:    floor_ff    <= csr_data;
               CSR_STOP_LOSS:     stop_ff     <= csr_data;
               default: ;
            endcase
         end
      end
      price_ff   <= price_in;
      head_ff    <= head_in;
      k_ff       <= k_in;
      n_ff       <= n_in;
      mag_ff     <= mag_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      res_ff     <= res_in;
      fast_ff    <= fast_in;
      slow_ff    <= slow_in;
      macd_ff    <= macd_in;
      signal_ff  <= signal_in;
      p_rebuy_ff <= p_rebuy_in;
      p_floor_ff <= p_floor_in;
      p_stop_ff  <= p_stop_in;
      up_ff      <= up_in;
      down_ff    <= down_in;
      rsp_ff     <= rsp_in;
   end

   // a waiting result is never overwritten: the commit holds while the consumer stalls
   a_commit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEC2 && rsp_valid_ff && rsp_stall) |=> state_ff == S_DEC2)
      else $error("result commit did not wait for the output register");

   // a divider result only arrives while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == S_DIV_WAIT)
      else $error("divider finished outside its wait state");

   // the mac sample index stays within the window
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD || state_ff == S_MAC) |-> (k_ff <= n_ff && k_ff != '0))
      else $error("history index out of window");

   // the trade state changes only at a commit or at a series start
   a_hold_change: assert property (@(posedge clock) disable iff (reset)
      (holding_ff != $past(holding_ff)) |->
         ($past(state_ff) == S_DEC2 || $past(state_ff) == S_IDLE))
      else $error("holding flag changed mid computation");
endmodule

>>> tb/macd_crossover_trader_tb.sv
// testbench of the macd crossover trader: directed and random price beats checked against a predictor
`timescale 1ns / 1ps
module macd_crossover_trader_tb import mct_pkg::*; ();

   localparam logic [2:0] CSR_UNUSED_INDEX = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   macd_crossover_trader dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // predictor copy of the block's settings and series state
   logic [5:0]  win_fast, win_slow, win_signal;
   logic [15:0] ratio_rebuy, ratio_floor, ratio_stop;
   longint      price_hist [0:HIST_DEPTH-1];
   longint      macd_hist [0:HIST_DEPTH-1];
   int          seen_count;
   logic signed [31:0] last_macd, last_signal;
   bit          in_position, has_traded;
   logic [31:0] trade_price;

   rsp_type     expected_rsp [$];
   int          error_count;
   bit          quiet;          // no idling on either side
   int          idle_cycles;    // cycles without any accepted beat
   int          stall_left;     // stalled cycles left in the current burst

   function automatic longint weighted_avg(input bit use_macd, input logic [5:0] window);
      int      n;
      longint  alpha, mag, num, den, x;
      bit      alternate;
      n = (window > MAX_WINDOW) ? MAX_WINDOW : int'(window);
      if (seen_count < n) n = seen_count;
      if (n <= 1) return use_macd ? macd_hist[n] : price_hist[n];
      if (n == 2) begin
         alpha = WONE;
         alternate = 1;
      end else begin
         alpha = ((longint'(n - 3)) << 24) / longint'(n - 1);
         alternate = 0;
      end
      mag = WONE;
      num = (use_macd ? macd_hist[0] : price_hist[0]) * WONE;
      den = WONE;
      for (int k = 1; k <= n; k++) begin
         mag = (mag * alpha) >>> 24;
         x = use_macd ? macd_hist[k] : price_hist[k];
         if (alternate && k[0]) begin
            num -= x * mag;
            den -= mag;
         end else begin
            num += x * mag;
            den += mag;
         end
      end
      if (den <= 0) den = WONE;
      return num / den;
   endfunction

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic void clear_predicted_series();
      for (int i = 0; i < HIST_DEPTH; i++) begin
         price_hist[i] = 0;
         macd_hist[i] = 0;
      end
      seen_count = 0;
      last_macd = 0;
      last_signal = 0;
      in_position = 0;
      has_traded = 0;
      trade_price = 0;
   endfunction

   // works out the result of one price beat and advances the predicted state
   function automatic rsp_type predict_trade(input req_type item);
      rsp_type     r;
      logic signed [31:0] m, s;
      logic [63:0] scaled, last;
      bit          up, down, buy, sell;
      scaled = {16'd0, item.price, 16'd0};
      if (item.start_series) clear_predicted_series();
      last = {32'd0, trade_price};
      for (int i = HIST_DEPTH - 1; i > 0; i--) price_hist[i] = price_hist[i-1];
      price_hist[0] = longint'(item.price);
      m = clamp32(weighted_avg(0, win_fast) - weighted_avg(0, win_slow));
      for (int i = HIST_DEPTH - 1; i > 0; i--) macd_hist[i] = macd_hist[i-1];
      macd_hist[0] = longint'(m);
      s = clamp32(weighted_avg(1, win_signal));
      up = seen_count >= 1 && last_macd < last_signal && m > s;
      down = seen_count >= 1 && last_macd > last_signal && m < s;
      buy = !in_position && (up || (has_traded && last != 0 &&
            scaled <= 64'(ratio_rebuy) * last));
      sell = in_position && down && last != 0 &&
             (scaled >= 64'(ratio_floor) * last || scaled <= 64'(ratio_stop) * last);
      r.macd_value = m;
      r.signal_value = s;
      r.action = ACT_NONE;
      if (buy || sell) begin
         r.action = buy ? ACT_BUY : ACT_SELL;
         in_position = !in_position;
         has_traded = 1;
         trade_price = item.price;
      end
      if (seen_count < MAX_WINDOW) seen_count++;
      last_macd = m;
      last_signal = s;
      return r;
   endfunction

   // one price beat: optional idle burst, then hold valid until accepted
   task automatic send_price(input logic [31:0] price, input bit start);
      req_type item;
      item.price = price;
      item.start_series = start;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsp.push_back(predict_trade(item));
   endtask

   task automatic release_req();
      req_valid <= 1'b0;
   endtask

   // wait for all results, then a latency margin so the block is idle
   task automatic drain();
      release_req();
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_FAST_WINDOW:   win_fast = value[5:0];
         CSR_SLOW_WINDOW:   win_slow = value[5:0];
         CSR_SIGNAL_WINDOW: win_signal = value[5:0];
         CSR_REBUY_RATIO:   ratio_rebuy = value;
         CSR_SELL_FLOOR:    ratio_floor = value;
         CSR_STOP_LOSS:     ratio_stop = value;
         default: ;
      endcase
   endtask

   task automatic write_windows(input logic [5:0] f, input logic [5:0] s, input logic [5:0] g);
      write_csr(CSR_FAST_WINDOW, {10'd0, f});
      write_csr(CSR_SLOW_WINDOW, {10'd0, s});
      write_csr(CSR_SIGNAL_WINDOW, {10'd0, g});
   endtask

   // random walk around a base, so crossovers and ratio bands actually trigger
   task automatic send_walk(input int count, input logic [31:0] base, input int step);
      logic [31:0] p;
      int          d;
      p = base;
      for (int i = 0; i < count; i++) begin
         d = $urandom_range(0, 2 * step) - step;
         if ($urandom_range(0, 19) == 0) d = d * 8;    // occasional sharp move
         p = p + d;
         send_price(p, i == 0);
      end
   endtask

   // result checker: random stall bursts, compare against oldest expectation
   always @(posedge clock) begin
      int next_left;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("result beat with nothing expected");
               error_count++;
            end else begin
               rsp_type e;
               e = expected_rsp.pop_front();
               if (rsp_data.macd_value !== e.macd_value) begin
                  $error("macd_value expected %0d actual %0d", e.macd_value,
                         rsp_data.macd_value);
                  error_count++;
               end
               if (rsp_data.signal_value !== e.signal_value) begin
                  $error("signal_value expected %0d actual %0d", e.signal_value,
                         rsp_data.signal_value);
                  error_count++;
               end
               if (rsp_data.action !== e.action) begin
                  $error("action expected %0d actual %0d", e.action, rsp_data.action);
                  error_count++;
               end
            end
         end
         // a stall burst of random length counts down, then drops
         next_left = stall_left;
         if (next_left != 0) next_left = next_left - 1;
         else if (!quiet && $urandom_range(0, 5) == 0) next_left = $urandom_range(1, 4);
         stall_left <= next_left;
         rsp_stall <= next_left != 0;
      end
   end

   // watchdog on cycles with no accepted beat
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("macd_crossover_trader_tb: errors");
         $finish;
      end
   end

   // extremes of price and series start, at the reset settings
   task automatic test_directed_extremes();
      send_price(32'h0000_0000, 1);
      send_price(32'hffff_ffff, 0);
      send_price(32'h0000_0000, 0);
      send_price(32'hffff_ffff, 0);
      send_price(32'h5555_5555, 0);
      send_price(32'haaaa_aaaa, 0);
      send_price(32'h0001_0000, 1);
      for (int i = 0; i < 6; i++) send_price(32'h0001_0000 + 32'(i * 4000), 0);
      for (int i = 0; i < 6; i++) send_price(32'h0001_6000 - 32'(i * 9000), 0);
      drain();
   endtask

   // window of two alternates weights and can saturate; window zero passes the price
   task automatic test_small_windows();
      write_windows(6'd2, 6'd0, 6'd2);
      send_price(32'h0000_0000, 1);
      send_price(32'hffff_ffff, 0);
      send_price(32'h0000_0000, 0);
      send_price(32'hffff_ffff, 0);
      drain();
      write_windows(6'd0, 6'd1, 6'd1);
      send_walk(20, 32'h0010_0000, 3000);
      drain();
   endtask

   // windows above the maximum clamp; ratio extremes 0 and all ones
   task automatic test_clamp_and_ratios();
      write_windows(6'd63, 6'd33, 6'd32);
      write_csr(CSR_REBUY_RATIO, 16'hffff);
      write_csr(CSR_SELL_FLOOR, 16'h0000);
      write_csr(CSR_STOP_LOSS, 16'hffff);
      send_walk(50, 32'h0040_0000, 20000);
      drain();
      write_csr(CSR_REBUY_RATIO, 16'h0000);
      write_csr(CSR_SELL_FLOOR, 16'hffff);
      write_csr(CSR_STOP_LOSS, 16'h0000);
      send_walk(50, 32'h0040_0000, 20000);
      drain();
   endtask

   // random settings and series; mostly small windows to keep the run short
   task automatic test_random_series(input int beats);
      int sent;
      sent = 0;
      while (sent < beats) begin
         int len;
         len = $urandom_range(10, 60);
         if ($urandom_range(0, 3) == 0) begin
            write_windows(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                          6'($urandom_range(0, 63)));
         end else begin
            write_windows(6'($urandom_range(0, 12)), 6'($urandom_range(0, 26)),
                          6'($urandom_range(0, 9)));
         end
         write_csr(CSR_REBUY_RATIO, 16'($urandom_range(50000, 65535)));
         write_csr(CSR_SELL_FLOOR, 16'($urandom_range(55000, 65535)));
         write_csr(CSR_STOP_LOSS, 16'($urandom_range(40000, 65535)));
         write_csr(CSR_UNUSED_INDEX, 16'($urandom));    // unused index, ignored
         if ($urandom_range(0, 4) == 0) begin
            for (int i = 0; i < len; i++) send_price($urandom, $urandom_range(0, 15) == 0);
         end else begin
            send_walk(len, $urandom_range(32'h0000_1000, 32'hf000_0000),
                      $urandom_range(100, 60000));
         end
         sent += len;
         drain();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      error_count = 0;
      quiet = 0;
      win_fast = RST_FAST_WINDOW;
      win_slow = RST_SLOW_WINDOW;
      win_signal = RST_SIGNAL_WINDOW;
      ratio_rebuy = RST_REBUY_RATIO;
      ratio_floor = RST_SELL_FLOOR;
      ratio_stop = RST_STOP_LOSS;
      clear_predicted_series();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_extremes();
      test_small_windows();
      test_clamp_and_ratios();
      test_random_series(1400);
      // last part: no idling on either side, default settings restored
      quiet = 1;
      write_windows(RST_FAST_WINDOW, RST_SLOW_WINDOW, RST_SIGNAL_WINDOW);
      write_csr(CSR_REBUY_RATIO, RST_REBUY_RATIO);
      write_csr(CSR_SELL_FLOOR, RST_SELL_FLOOR);
      write_csr(CSR_STOP_LOSS, RST_STOP_LOSS);
      send_walk(100, 32'h0064_0000, 30000);
      drain();

      if (error_count == 0) $display("macd_crossover_trader_tb: clean");
      else $display("macd_crossover_trader_tb: errors");
      $finish;
   end

endmodule
